>>> sv/mdio_c22_pkg.sv
package mdio_c22_pkg;

  localparam int PreambleBits = 32;
  localparam int FrameBits    = PreambleBits + 32;
  localparam int TotalHalves  = 2 * FrameBits + 2;
  localparam int ReadFirstBit = PreambleBits + 14;

  localparam int HalfW = $clog2(TotalHalves);
  localparam int IdxW  = $clog2(FrameBits);

  localparam logic [HalfW-1:0] LastHalf     = HalfW'(TotalHalves - 1);
  localparam logic [HalfW-1:0] LastBitHalf  = HalfW'(2 * FrameBits);
  localparam logic [IdxW-1:0]  LastIdx      = IdxW'(FrameBits - 1);
  localparam logic [IdxW-1:0]  ReadFirstIdx = IdxW'(ReadFirstBit);
  localparam logic [IdxW-1:0]  ReadDataIdx  = IdxW'(ReadFirstBit + 2);

  localparam logic [1:0] StartBits   = 2'b01;
  localparam logic [1:0] OpBitsRead  = 2'b10;
  localparam logic [1:0] OpBitsWrite = 2'b01;
  localparam logic [1:0] TaWrite     = 2'b10;
  localparam logic [1:0] TaExpected  = 2'b10;

  typedef enum logic [1:0] {
    OpTick  = 2'd0,
    OpRead  = 2'd1,
    OpWrite = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StTaFail = 2'd1,
    StReject = 2'd2
  } status_e;

  typedef struct packed {
    logic oe;
    logic data;
    logic mdc;
  } lines_t;

  localparam lines_t LinesRest = '{oe: 1'b0, data: 1'b1, mdc: 1'b0};

endpackage

>>> sv/mdio_clause22_frame_master.sv
// Clause 22 MDIO master. A read or write request loads the whole serial frame; each tick
// request then advances the frame by one half MDC period and returns the line levels for
// the next half, so a frame takes 2 * (preamble + 32) + 2 ticks. Read data and the
// turnaround check are sampled from mdio_in_i at the end of each high half of the read
// phase, and the final tick reports done with status and read data. Read or write requests
// arriving while a frame is running are rejected with status 2 and do not advance the frame.
// Every request yields exactly one result, which is written to the output register at
// the edge that accepts the request. One request can be taken per clock cycle, but only
// while the output register is empty or its result is taken in the same cycle.
module mdio_clause22_frame_master
  import mdio_c22_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [4:0]  phy_addr_i,
  input  logic [4:0]  reg_addr_i,
  input  logic [15:0] write_data_i,
  input  logic        mdio_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        mdc_o,
  output logic        mdio_out_o,
  output logic        mdio_oe_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [1:0]  status_o,
  output logic [15:0] read_data_o
);

  logic [FrameBits-1:0] frame_shift_q, frame_shift_d;
  logic [HalfW-1:0]     half_count_q, half_count_d;
  logic                 frame_active_q, frame_active_d;
  logic                 is_read_q, is_read_d;
  logic [15:0]          read_shift_q, read_shift_d;
  logic [1:0]           ta_bits_q, ta_bits_d;
  lines_t               lines_q, lines_d;

  logic                 out_valid_q;
  lines_t               res_lines_q;
  logic                 res_busy_q, res_busy_d;
  logic                 res_done_q, res_done_d;
  status_e              res_status_q, res_status_d;
  logic [15:0]          res_rdata_q, res_rdata_d;

  logic                 accept;
  logic [HalfW-1:0]     hm1;
  logic [IdxW-1:0]      sample_idx;
  logic [HalfW-1:0]     next_half;

  function automatic lines_t levels_for_half(logic [HalfW-1:0] h,
                                             logic [FrameBits-1:0] frame,
                                             logic rd);
    logic [HalfW-1:0] m1;
    logic [IdxW-1:0]  idx;
    lines_t           lv;
    m1  = h - 1'b1;
    idx = m1[IdxW:1];
    lv  = LinesRest;
    if (h != '0 && h < LastHalf) begin
      lv.mdc = m1[0];
      if (!(rd && idx >= ReadFirstIdx)) begin
        lv.oe   = 1'b1;
        lv.data = frame[LastIdx - idx];
      end
    end
    return lv;
  endfunction

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign hm1        = half_count_q - 1'b1;
  assign sample_idx = hm1[IdxW:1];
  assign next_half  = half_count_q + 1'b1;

  always_comb begin
    frame_shift_d  = frame_shift_q;
    half_count_d   = half_count_q;
    frame_active_d = frame_active_q;
    is_read_d      = is_read_q;
    read_shift_d   = read_shift_q;
    ta_bits_d      = ta_bits_q;
    lines_d        = lines_q;
    res_done_d     = 1'b0;
    res_status_d   = StOk;
    res_rdata_d    = '0;
    if (accept) begin
      unique case (opcode_e'(opcode_i))
        OpRead, OpWrite: begin
          if (frame_active_q) begin
            res_status_d = StReject;
          end else begin
            is_read_d      = (opcode_e'(opcode_i) == OpRead);
            frame_shift_d  = {{PreambleBits{1'b1}}, StartBits,
                              is_read_d ? OpBitsRead : OpBitsWrite,
                              phy_addr_i, reg_addr_i,
                              is_read_d ? 2'b00 : TaWrite,
                              is_read_d ? 16'h0000 : write_data_i};
            half_count_d   = '0;
            read_shift_d   = '0;
            ta_bits_d      = '0;
            frame_active_d = 1'b1;
            lines_d        = LinesRest;
          end
        end
        OpTick: begin
          if (frame_active_q) begin
            if (is_read_q && half_count_q != '0 && half_count_q <= LastBitHalf &&
                hm1[0] && sample_idx >= ReadFirstIdx) begin
              if (sample_idx < ReadDataIdx) begin
                ta_bits_d = {ta_bits_q[0], mdio_in_i};
              end else begin
                read_shift_d = {read_shift_q[14:0], mdio_in_i};
              end
            end
            if (half_count_q == LastHalf) begin
              frame_active_d = 1'b0;
              half_count_d   = '0;
              lines_d        = LinesRest;
              res_done_d     = 1'b1;
              if (is_read_q) begin
                if (ta_bits_d != TaExpected) begin
                  res_status_d = StTaFail;
                end else begin
                  res_rdata_d = read_shift_d;
                end
              end
            end else begin
              half_count_d = next_half;
              lines_d      = levels_for_half(next_half, frame_shift_q, is_read_q);
            end
          end
        end
        default: begin
        end
      endcase
    end
    res_busy_d = frame_active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_shift_q  <= '0;
      half_count_q   <= '0;
      frame_active_q <= 1'b0;
      is_read_q      <= 1'b0;
      read_shift_q   <= '0;
      ta_bits_q      <= '0;
      lines_q        <= LinesRest;
      out_valid_q    <= 1'b0;
    end else begin
      frame_shift_q  <= frame_shift_d;
      half_count_q   <= half_count_d;
      frame_active_q <= frame_active_d;
      is_read_q      <= is_read_d;
      read_shift_q   <= read_shift_d;
      ta_bits_q      <= ta_bits_d;
      lines_q        <= lines_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_lines_q  <= lines_d;
      res_busy_q   <= res_busy_d;
      res_done_q   <= res_done_d;
      res_status_q <= res_status_d;
      res_rdata_q  <= res_rdata_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign mdc_o       = res_lines_q.mdc;
  assign mdio_out_o  = res_lines_q.data;
  assign mdio_oe_o   = res_lines_q.oe;
  assign busy_res_o  = res_busy_q;
  assign done_res_o  = res_done_q;
  assign status_o    = res_status_q;
  assign read_data_o = res_rdata_q;

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_done_q |-> !res_busy_q)
    else $error("done result reports busy");

  a_reject_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_status_q == StReject |-> res_busy_q && !res_done_q)
    else $error("rejected request outside a frame");

  a_idle_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !frame_active_q |-> half_count_q == '0 && lines_q == LinesRest)
    else $error("idle state not at rest");

  a_rdata_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_rdata_q != '0 |-> res_done_q && res_status_q == StOk)
    else $error("read data outside a good done result");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    half_count_q <= LastHalf)
    else $error("half period count out of range");

endmodule
